// ----- rtl/sdf_pkg.sv -----
package sdf_pkg;

	// Operand and decimal digit sizes
	localparam int VAL_W     = 64;
	localparam int DIGITS    = 20;
	localparam int BCD_W     = DIGITS * 4;
	localparam int CNT_W     = $clog2(VAL_W);
	localparam int DIG_IDX_W = $clog2(DIGITS);
	localparam int LEN_W     = 7;
	localparam int FW_W      = 6;
	localparam int MODE_W    = 3;
	localparam int CH_W      = 8;

	// Request word layout (s_tdata), lowest bit first
	localparam int IN_VAL_LSB   = 0;
	localparam int IN_FW_LSB    = IN_VAL_LSB + VAL_W;
	localparam int IN_PREC_LSB  = IN_FW_LSB + FW_W;
	localparam int IN_HASP_BIT  = IN_PREC_LSB + FW_W;
	localparam int IN_LEFT_BIT  = IN_HASP_BIT + 1;
	localparam int IN_PLUS_BIT  = IN_LEFT_BIT + 1;
	localparam int IN_SPACE_BIT = IN_PLUS_BIT + 1;
	localparam int IN_ZERO_BIT  = IN_SPACE_BIT + 1;
	localparam int IN_ALT_BIT   = IN_ZERO_BIT + 1;
	localparam int IN_TDATA_W   = ((IN_ALT_BIT + 1 + 7) / 8) * 8;

	// Result word layout (m_tdata, m_tuser)
	localparam int OUT_CH_LSB   = 0;
	localparam int OUT_TOT_LSB  = OUT_CH_LSB + CH_W;
	localparam int OUT_TDATA_W  = ((OUT_TOT_LSB + LEN_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W  = 2;
	localparam int TU_VALID_BIT = 0;
	localparam int TU_ERR_BIT   = 1;

	// Length modifier codes
	localparam logic [MODE_W-1:0] MODE_LONG    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INVALID = 3'd7;

	// ASCII characters
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEN,
		ST_EMIT,
		ST_MARK
	} st_t;

	// Control between sequencer and conversion unit
	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

endpackage

// ----- rtl/sdf_bcd.sv -----
module sdf_bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sdf_pkg::VAL_W-1:0]   bin,
	output sdf_pkg::bcd_stat_t          stat,
	output logic [sdf_pkg::BCD_W-1:0]   bcd
);
	import sdf_pkg::*;

	logic [VAL_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] corr;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			corr[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                           : bcd_q[i*4 +: 4];
		end
	end

	// Sequence control: one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(VAL_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift binary into decimal digits
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {corr[BCD_W-2:0], bin_q[VAL_W-1]};
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == CNT_W'(VAL_W - 1));
	assign bcd       = bcd_q;

endmodule

// ----- rtl/signed_decimal_formatter.sv -----
// Channel  Dir  Group                    Contents
// request  in   s_tvalid/s_tready        s_tdata: value, width, precision, flags; s_tuser: mode
// result   out  m_tvalid/m_tready/tlast  m_tdata: character, total_length; m_tuser: flags
//
// One conversion runs through the accept, the shift-and-add-3 binary to
// decimal unit and the length set-up state, then emits one character per
// cycle while m_tready allows (0 to 64 characters); error requests skip the
// conversion. s_tready is high only while the sequencer is idle.
// Results stall on m_tready through a single output register.
// arst_n clears the sequencer, the conversion unit and m_tvalid.
module signed_decimal_formatter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// value, field_width, digit_precision, has_precision, left_align,
	// force_plus, space_sign, zero_fill, alternate_form, zero fill
	input  logic [sdf_pkg::IN_TDATA_W-1:0]    s_tdata,
	// mode
	input  logic [sdf_pkg::MODE_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// character, total_length, zero fill
	output logic [sdf_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// char_valid, error
	output logic [sdf_pkg::OUT_TUSER_W-1:0]   m_tuser,
	output logic                              m_tlast
);
	import sdf_pkg::*;

	st_t state_q, state_d;

	// Request fields
	logic [VAL_W-1:0]  in_val;
	logic [FW_W-1:0]   in_fw, in_prec;
	logic              in_err, in_neg;
	logic [VAL_W-1:0]  in_mag;
	logic [31:0]       low32;

	// Held spec
	logic [FW_W-1:0]   width_q, prec_q;
	logic              has_prec_q, left_q, plus_q, space_q, zero_q;
	logic              neg_q, mag_zero_q, mark_err_q;

	// Field layout
	logic [LEN_W-1:0]     total_q, b_sign_q, b_zero_q, b_dig_q, b_tail_q, pos_q;
	logic [CH_W-1:0]      sign_ch_q;
	logic [DIG_IDX_W-1:0] dig_idx_q;

	// Conversion unit
	logic              bcd_start;
	bcd_stat_t         bcd_stat;
	logic [BCD_W-1:0]  bcd;

	// Output register
	logic              m_valid_q, m_last_q, m_cv_q, m_err_q;
	logic [CH_W-1:0]   m_ch_q;
	logic [LEN_W-1:0]  m_tot_q;
	logic              slot_free, accept;

	// Length set-up terms
	logic [DIG_IDX_W-1:0] hi;
	logic                 nz;
	logic [DIG_IDX_W-1:0] nd, nd_raw;
	logic [FW_W-1:0]      ndig;
	logic                 sign_len, zf;
	logic [LEN_W-1:0]     body, total, pad, lead, b_zero, b_dig;
	logic [CH_W-1:0]      sign_ch;

	// Emission terms
	logic [3:0]        nib;
	logic [CH_W-1:0]   emit_ch;
	logic              emit_dig;

	// Loads into the output register
	logic              ld, ld_cv, ld_last, ld_err;
	logic [CH_W-1:0]   ld_ch;
	logic [LEN_W-1:0]  ld_tot;
	logic              len_go, emit_go, mark_go;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	// Unpack request and take magnitude
	always_comb begin
		in_val  = s_tdata[IN_VAL_LSB +: VAL_W];
		in_fw   = s_tdata[IN_FW_LSB +: FW_W];
		in_prec = s_tdata[IN_PREC_LSB +: FW_W];
		in_err  = s_tdata[IN_ALT_BIT] || (s_tuser == MODE_INVALID);
		low32   = in_val[31:0];
		if (s_tuser <= MODE_LONG) begin
			in_neg = low32[31];
			in_mag = {32'd0, (in_neg ? (32'd0 - low32) : low32)};
		end else begin
			in_neg = in_val[VAL_W-1];
			in_mag = in_neg ? (VAL_W'(0) - in_val) : in_val;
		end
	end

	assign bcd_start = accept && !in_err;

	sdf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (in_mag),
		.stat   (bcd_stat),
		.bcd    (bcd)
	);

	// Hold the spec of an accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			width_q    <= in_fw;
			prec_q     <= in_prec;
			has_prec_q <= s_tdata[IN_HASP_BIT];
			left_q     <= s_tdata[IN_LEFT_BIT];
			plus_q     <= s_tdata[IN_PLUS_BIT];
			space_q    <= s_tdata[IN_SPACE_BIT];
			zero_q     <= s_tdata[IN_ZERO_BIT];
			neg_q      <= in_neg;
			mag_zero_q <= (in_mag == '0);
		end
	end

	// Find the highest non-zero digit and lay out the field
	always_comb begin
		hi = '0;
		nz = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[i*4 +: 4] != 4'd0) begin
				hi = DIG_IDX_W'(i);
				nz = 1'b1;
			end
		end
		nd_raw   = nz ? hi + 1'b1 : DIG_IDX_W'(1);
		nd       = (has_prec_q && (prec_q == '0) && mag_zero_q) ? '0 : nd_raw;
		ndig     = (has_prec_q && (prec_q > FW_W'(nd))) ? prec_q : FW_W'(nd);
		sign_len = neg_q || plus_q || space_q;
		sign_ch  = neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);
		body     = LEN_W'(ndig) + LEN_W'(sign_len);
		total    = (body > LEN_W'(width_q)) ? body : LEN_W'(width_q);
		pad      = total - body;
		zf       = zero_q && !has_prec_q && !left_q;
		lead     = (!left_q && !zf) ? pad : '0;
		b_zero   = lead + LEN_W'(sign_len);
		b_dig    = b_zero + (zf ? pad : '0) + LEN_W'(ndig - FW_W'(nd));
	end

	// Pick the digit under the read index
	always_comb begin
		nib = 4'd0;
		for (int i = 0; i < DIGITS; i++) begin
			if (dig_idx_q == DIG_IDX_W'(i)) begin
				nib = bcd[i*4 +: 4];
			end
		end
	end

	// Character at the current position
	always_comb begin
		emit_dig = 1'b0;
		priority if (pos_q < b_sign_q) begin
			emit_ch = CH_SPACE;
		end else if (pos_q < b_zero_q) begin
			emit_ch = sign_ch_q;
		end else if (pos_q < b_dig_q) begin
			emit_ch = CH_ZERO;
		end else if (pos_q < b_tail_q) begin
			emit_ch  = CH_ZERO | {4'd0, nib};
			emit_dig = 1'b1;
		end else begin
			emit_ch = CH_SPACE;
		end
	end

	// Next state and output loads
	always_comb begin
		state_d = state_q;
		ld      = 1'b0;
		ld_ch   = '0;
		ld_cv   = 1'b0;
		ld_last = 1'b0;
		ld_err  = 1'b0;
		ld_tot  = '0;
		len_go  = 1'b0;
		emit_go = 1'b0;
		mark_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					mark_go = in_err;
					state_d = in_err ? ST_MARK : ST_CONV;
				end
			end
			ST_CONV: begin
				if (bcd_stat.done) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				len_go  = 1'b1;
				state_d = (total == '0) ? ST_MARK : ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit_go = 1'b1;
					ld      = 1'b1;
					ld_ch   = emit_ch;
					ld_cv   = 1'b1;
					ld_last = (pos_q == total_q - 1'b1);
					ld_tot  = total_q;
					if (ld_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MARK: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_last = 1'b1;
					ld_err  = mark_err_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the layout, advance position and digit index
	always_ff @(posedge clk) begin
		if (accept) begin
			mark_err_q <= mark_go;
		end
		if (len_go) begin
			mark_err_q <= 1'b0;
			total_q    <= total;
			b_sign_q   <= lead;
			b_zero_q   <= b_zero;
			b_dig_q    <= b_dig;
			b_tail_q   <= b_dig + LEN_W'(nd);
			sign_ch_q  <= sign_ch;
			dig_idx_q  <= nd - 1'b1;
			pos_q      <= '0;
		end else if (emit_go) begin
			pos_q <= pos_q + 1'b1;
			if (emit_dig) begin
				dig_idx_q <= dig_idx_q - 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ld) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_ch_q   <= ld_ch;
			m_cv_q   <= ld_cv;
			m_last_q <= ld_last;
			m_err_q  <= ld_err;
			m_tot_q  <= ld_tot;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_TOT_LSB - LEN_W){1'b0}}, m_tot_q, m_ch_q};
	assign m_tuser  = {m_err_q, m_cv_q};

endmodule

// ----- rtl/sdf_chk.sv -----
module sdf_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [sdf_pkg::IN_TDATA_W-1:0]    s_tdata,
	input logic [sdf_pkg::MODE_W-1:0]        s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sdf_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input logic [sdf_pkg::OUT_TUSER_W-1:0]   m_tuser,
	input logic                              m_tlast
);
	import sdf_pkg::*;

	// One request at a time: drop ready right after an accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while a conversion was in progress");

	// An error result is a lone marker
	a_err_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[TU_ERR_BIT] |-> m_tlast && !m_tuser[TU_VALID_BIT])
		else $error("error result not a closing marker");

	// A marker closes the conversion and reports an empty field
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[TU_VALID_BIT]
		|-> m_tlast && (m_tdata[OUT_TOT_LSB +: LEN_W] == '0))
		else $error("marker result with non-zero length or not last");

	// Real characters come with a non-empty field length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[TU_VALID_BIT] |-> (m_tdata[OUT_TOT_LSB +: LEN_W] != '0))
		else $error("character result with zero field length");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind signed_decimal_formatter sdf_chk u_sdf_chk (.*);

// ----- test/sdf_field_checker.sv -----
module sdf_field_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// value, field_width, digit_precision, has_precision, left_align,
	// force_plus, space_sign, zero_fill, alternate_form, zero fill
	input  logic [sdf_pkg::IN_TDATA_W-1:0]  s_tdata,
	// mode
	input  logic [sdf_pkg::MODE_W-1:0]      s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// character, total_length, zero fill
	input  logic [sdf_pkg::OUT_TDATA_W-1:0] m_tdata,
	// char_valid, error
	input  logic [sdf_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                          m_tlast,
	output int                            mismatches,
	output int                            awaiting,
	output int                            results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import sdf_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic             valid;
		logic             last;
		logic             err;
		logic [LEN_W-1:0] total;
	} field_char_t;

	field_char_t expected_chars[$];
	int          fail_tally = 0;
	int          seen_tally = 0;

	// Queue the characters that one request should produce
	function automatic void render_field(
		input logic [VAL_W-1:0]  value,
		input logic [MODE_W-1:0] mode,
		input logic [FW_W-1:0]   fw,
		input logic [FW_W-1:0]   prec,
		input logic              hasp,
		input logic              left,
		input logic              plus,
		input logic              space,
		input logic              zero,
		input logic              alt
	);
		logic [VAL_W-1:0] mag;
		logic [31:0]      low;
		logic             neg;
		logic [CH_W-1:0]  digit_buf [0:23];
		logic [CH_W-1:0]  field [0:127];
		logic [CH_W-1:0]  sign_ch;
		logic             has_sign;
		logic             zero_pad;
		int               nd;
		int               ndig;
		int               body;
		int               total;
		int               pad;
		int               pos;
		field_char_t      rec;

		// Undefined flag or modifier: single error marker
		if (alt || mode == MODE_INVALID) begin
			rec = '{ch: '0, valid: 1'b0, last: 1'b1, err: 1'b1, total: '0};
			expected_chars.push_back(rec);
			return;
		end

		// Magnitude and sign from 32 or 64 bits
		if (mode <= MODE_LONG) begin
			low = value[31:0];
			neg = low[31];
			if (neg)
				low = ~low + 32'd1;
			mag = {32'd0, low};
		end else begin
			neg = value[VAL_W-1];
			mag = neg ? (~value + 64'd1) : value;
		end

		// Decimal digits, least significant first
		nd = 0;
		if (!(hasp && prec == '0 && mag == '0)) begin
			do begin
				digit_buf[nd] = CH_ZERO + CH_W'(mag % 64'd10);
				mag = mag / 64'd10;
				nd++;
			end while (mag != '0);
		end
		ndig = nd;
		if (hasp && int'(prec) > ndig)
			ndig = int'(prec);

		// Minus beats plus, plus beats space
		has_sign = 1'b1;
		if (neg)
			sign_ch = CH_MINUS;
		else if (plus)
			sign_ch = CH_PLUS;
		else if (space)
			sign_ch = CH_SPACE;
		else begin
			sign_ch = '0;
			has_sign = 1'b0;
		end

		body  = int'(has_sign) + ndig;
		total = (body > int'(fw)) ? body : int'(fw);
		pad   = total - body;

		if (total == 0) begin
			rec = '{ch: '0, valid: 1'b0, last: 1'b1, err: 1'b0, total: '0};
			expected_chars.push_back(rec);
			return;
		end

		// Zero fill only applies right-aligned without a precision
		zero_pad = zero && !hasp && !left;
		pos = 0;
		if (!left && !zero_pad)
			for (int i = 0; i < pad; i++) field[pos++] = CH_SPACE;
		if (has_sign)
			field[pos++] = sign_ch;
		if (zero_pad)
			for (int i = 0; i < pad; i++) field[pos++] = CH_ZERO;
		for (int i = nd; i < ndig; i++) field[pos++] = CH_ZERO;
		for (int i = nd; i > 0; i--) field[pos++] = digit_buf[i-1];
		if (left)
			for (int i = 0; i < pad; i++) field[pos++] = CH_SPACE;

		for (int i = 0; i < pos; i++) begin
			rec.ch    = field[i];
			rec.valid = 1'b1;
			rec.last  = (i == pos - 1);
			rec.err   = 1'b0;
			rec.total = LEN_W'(total);
			expected_chars.push_back(rec);
		end
	endfunction

	// Predict on each accepted request, then compare each accepted result
	always @(posedge clk) begin
		field_char_t got;
		field_char_t want;

		if (arst_n) begin
			if (s_tvalid && s_tready)
				render_field(s_tdata[IN_VAL_LSB +: VAL_W], s_tuser,
					s_tdata[IN_FW_LSB +: FW_W], s_tdata[IN_PREC_LSB +: FW_W],
					s_tdata[IN_HASP_BIT], s_tdata[IN_LEFT_BIT], s_tdata[IN_PLUS_BIT],
					s_tdata[IN_SPACE_BIT], s_tdata[IN_ZERO_BIT], s_tdata[IN_ALT_BIT]);

			if (m_tvalid && m_tready) begin
				got.ch    = m_tdata[OUT_CH_LSB +: CH_W];
				got.valid = m_tuser[TU_VALID_BIT];
				got.last  = m_tlast;
				got.err   = m_tuser[TU_ERR_BIT];
				got.total = m_tdata[OUT_TOT_LSB +: LEN_W];
				seen_tally++;
				if (expected_chars.size() == 0) begin
					fail_tally++;
					$display("%0t: expected none, got ch=%h v=%b l=%b e=%b len=%0d",
						$time, got.ch, got.valid, got.last, got.err, got.total);
				end else begin
					want = expected_chars.pop_front();
					if (got !== want) begin
						fail_tally++;
						$display("%0t: expected ch=%h v=%b l=%b e=%b len=%0d",
							$time, want.ch, want.valid, want.last, want.err,
							want.total);
						$display("%0t:      got ch=%h v=%b l=%b e=%b len=%0d",
							$time, got.ch, got.valid, got.last, got.err, got.total);
					end
				end
			end
		end

		mismatches      <= fail_tally;
		awaiting        <= expected_chars.size();
		results_checked <= seen_tally;
	end

endmodule

// ----- test/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdf_pkg::*;

	// Length modifiers without a package name
	localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SHORT    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CHAR     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LONGLONG = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INTMAX   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SIZE     = 3'd6;

	localparam int RANDOM_REQUESTS = 400;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int TAIL_CYCLES     = 140;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;

	int mismatches;
	int awaiting;
	int results_checked;

	int       cycles      = 0;
	int       burst_left  = 1;
	int       sent        = 0;
	int       errors_sent = 0;
	logic [9:0] stall_tick = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	signed_decimal_formatter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sdf_field_checker field_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.awaiting        (awaiting),
		.results_checked (results_checked)
	);

	// Receiver back-pressure: cycle through four stall styles
	always @(posedge clk) begin
		stall_tick <= stall_tick + 10'd1;
		case (stall_tick[9:8])
			2'd0: begin
				m_tready <= 1'b1;
			end
			2'd1: begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
			2'd2: begin
				m_tready <= (stall_tick[3:0] < 4'd11);
			end
			default: begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited", cycles, awaiting);
			$display("Mismatches found");
			$finish;
		end
	end

	// Present one request, hold until accepted, then maybe drop valid for a gap
	task automatic issue_request(
		input logic [VAL_W-1:0]  value,
		input logic [MODE_W-1:0] mode,
		input logic [FW_W-1:0]   fw,
		input logic [FW_W-1:0]   prec,
		input logic              hasp,
		input logic              left,
		input logic              plus,
		input logic              space,
		input logic              zero,
		input logic              alt
	);
		logic [IN_TDATA_W-1:0] word;
		int                    gap;

		word = '0;
		word[IN_VAL_LSB +: VAL_W]  = value;
		word[IN_FW_LSB +: FW_W]    = fw;
		word[IN_PREC_LSB +: FW_W]  = prec;
		word[IN_HASP_BIT]  = hasp;
		word[IN_LEFT_BIT]  = left;
		word[IN_PLUS_BIT]  = plus;
		word[IN_SPACE_BIT] = space;
		word[IN_ZERO_BIT]  = zero;
		word[IN_ALT_BIT]   = alt;

		s_tdata  <= word;
		s_tuser  <= mode;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);

		sent++;
		if (alt || mode == MODE_INVALID)
			errors_sent++;

		burst_left--;
		if (burst_left <= 0) begin
			gap = ((sent / 40) % 4 == 3) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	initial begin
		logic [VAL_W-1:0]  v;
		logic [MODE_W-1:0] md;
		logic [FW_W-1:0]   fw;
		logic [FW_W-1:0]   pr;
		int                kind;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_NONE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every modifier, flags and special cases
		issue_request(64'd0, MODE_NONE, 6'd0, 6'd0, 0, 0, 0, 0, 0, 0);
		issue_request(64'd0, MODE_NONE, 6'd0, 6'd0, 1, 0, 0, 0, 0, 0);
		issue_request(64'd0, MODE_SHORT, 6'd5, 6'd0, 1, 0, 0, 0, 0, 0);
		issue_request(64'd0, MODE_CHAR, 6'd0, 6'd0, 1, 0, 1, 0, 0, 0);
		issue_request(64'h8000_0000_0000_0000, MODE_LONGLONG, 6'd0, 6'd0, 0, 0, 0, 0, 0, 0);
		issue_request(64'h7FFF_FFFF_FFFF_FFFF, MODE_INTMAX, 6'd0, 6'd0, 0, 0, 1, 0, 0, 0);
		issue_request(64'h1234_5678_8000_0000, MODE_NONE, 6'd0, 6'd0, 0, 0, 0, 0, 0, 0);
		issue_request(64'hFFFF_FFFF_7FFF_FFFF, MODE_SHORT, 6'd0, 6'd0, 0, 0, 0, 1, 0, 0);
		issue_request(64'hFFFF_FFFF_FFFF_FFFF, MODE_CHAR, 6'd63, 6'd0, 0, 1, 0, 0, 0, 0);
		issue_request(64'd42, MODE_LONG, 6'd0, 6'd0, 0, 0, 1, 1, 0, 0);
		issue_request(64'd42, MODE_SIZE, 6'd0, 6'd0, 0, 0, 0, 1, 0, 0);
		issue_request(-64'sd42, MODE_NONE, 6'd10, 6'd0, 0, 0, 0, 0, 1, 0);
		issue_request(-64'sd42, MODE_NONE, 6'd10, 6'd5, 1, 0, 0, 0, 1, 0);
		issue_request(-64'sd42, MODE_NONE, 6'd10, 6'd0, 0, 1, 0, 0, 1, 0);
		issue_request(64'd7, MODE_NONE, 6'd0, 6'd0, 0, 0, 0, 0, 0, 1);
		issue_request(64'd7, MODE_INVALID, 6'd0, 6'd0, 0, 0, 0, 0, 0, 0);
		issue_request(64'd7, MODE_INVALID, 6'd9, 6'd3, 1, 1, 1, 1, 1, 1);
		issue_request(64'd123, MODE_LONGLONG, 6'd63, 6'd63, 1, 0, 1, 0, 0, 0);
		issue_request(64'hFFFF_FFFF_FFFF_FFFF, MODE_LONGLONG, 6'd63, 6'd0, 1, 0, 0, 0, 1, 0);
		issue_request(64'd0, MODE_INTMAX, 6'd63, 6'd0, 0, 0, 1, 1, 1, 0);
		issue_request(64'd99, MODE_SIZE, 6'd8, 6'd4, 1, 1, 0, 1, 0, 0);
		issue_request(64'h8000_0000_0000_0000, MODE_LONGLONG, 6'd63, 6'd63, 1, 1, 1, 1, 1, 0);

		// Random: mixed value shapes, mostly small sizes
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			kind = $urandom_range(0, 7);
			v = {$urandom, $urandom};
			case (kind)
				2: begin
					v = 64'($urandom_range(0, 999));
					if ($urandom_range(0, 1))
						v = ~v + 64'd1;
				end
				3: begin
					case ($urandom_range(0, 3))
						0: v[31:0] = 32'h8000_0000;
						1: v[31:0] = 32'h7FFF_FFFF;
						2: v[31:0] = 32'hFFFF_FFFF;
						default: v[31:0] = 32'd0;
					endcase
				end
				4: begin
					v = v >> $urandom_range(0, 63);
					if ($urandom_range(0, 1))
						v = ~v + 64'd1;
				end
				5: begin
					case ($urandom_range(0, 3))
						0: v = 64'h8000_0000_0000_0000;
						1: v = 64'h7FFF_FFFF_FFFF_FFFF;
						2: v = 64'hFFFF_FFFF_FFFF_FFFF;
						default: v = 64'd0;
					endcase
				end
				6: begin
					v = 64'd1;
					repeat ($urandom_range(0, 18)) v = v * 64'd10;
					v = v - 64'($urandom_range(0, 1));
					if ($urandom_range(0, 1))
						v = ~v + 64'd1;
				end
				default: begin
				end
			endcase

			md = ($urandom_range(0, 15) == 0) ? MODE_INVALID
				: MODE_W'($urandom_range(0, int'(MODE_INVALID) - 1));
			fw = ($urandom_range(0, 3) == 0) ? FW_W'($urandom_range(0, 63))
				: FW_W'($urandom_range(0, 12));
			pr = ($urandom_range(0, 3) == 0) ? FW_W'($urandom_range(0, 63))
				: FW_W'($urandom_range(0, 8));

			issue_request(v, md, fw, pr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
		end

		// Drain: wait for every expected character, then let the block settle
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Formatted %0d requests (%0d in error), %0d result characters",
			sent, errors_sent, results_checked);
		$display("Covered all length modifiers, widths and precisions up to 63, sign and pad flags");
		if (mismatches == 0 && awaiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
